FILE: rtl/rgfb_pkg.sv
// ----------------------------------------------------------------------------
// rgfb_pkg
// shared types and constants of the rotated grid fog blend unit
// ----------------------------------------------------------------------------
package rgfb_pkg;

   localparam int MAX_GRID_DIM_DEFAULT = 64;
   localparam int FRACTION_SCALE       = 256;

   localparam logic [7:0] FOG_RED   = 8'd45;
   localparam logic [7:0] FOG_GREEN = 8'd38;
   localparam logic [7:0] FOG_BLUE  = 8'd30;

   localparam logic [7:0] ALPHA_UNSEEN   = 8'd180;
   localparam logic [7:0] ALPHA_EXPLORED = 8'd60;
   localparam logic [7:0] ALPHA_VISIBLE  = 8'd0;
   localparam logic [7:0] CHANNEL_MAX    = 8'd255;

   localparam logic [1:0] CELL_EXPLORED = 2'd1;
   localparam logic [1:0] CELL_VISIBLE  = 2'd2;

   localparam logic [10:0]       IMAGE_WIDTH_RESET  = 11'd256;
   localparam logic [10:0]       IMAGE_HEIGHT_RESET = 11'd256;
   localparam logic [6:0]        GRID_WIDTH_RESET   = 7'd64;
   localparam logic [6:0]        GRID_HEIGHT_RESET  = 7'd64;
   localparam logic signed [15:0] YAW_COSINE_RESET  = 16'sd16384;
   localparam logic signed [15:0] YAW_SINE_RESET    = 16'sd0;
   localparam logic [23:0]       SCALE_H_RESET      = 24'd16384;
   localparam logic [23:0]       SCALE_V_RESET      = 24'd16384;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_GRID_WIDTH,
      CSR_GRID_HEIGHT,
      CSR_YAW_COSINE,
      CSR_YAW_SINE,
      CSR_SCALE_HORIZONTAL,
      CSR_SCALE_VERTICAL
   } csr_index_type;

   typedef enum logic {
      OP_WRITE,
      OP_COMPOSE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] cell_index;
      logic [1:0]  cell_state;
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [7:0]  base_red;
      logic [7:0]  base_green;
      logic [7:0]  base_blue;
   } item_type;

   typedef struct packed {
      logic [10:0]        image_width;
      logic [10:0]        image_height;
      logic [6:0]         grid_width;
      logic [6:0]         grid_height;
      logic signed [15:0] yaw_cosine;
      logic signed [15:0] yaw_sine;
      logic [23:0]        scale_horizontal;
      logic [23:0]        scale_vertical;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROT1,
      ST_ROT2,
      ST_ROT3,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_GRID_Y,
      ST_SPLIT,
      ST_ADDR,
      ST_READ,
      ST_LERP_ROW,
      ST_LERP_COL,
      ST_DIVIDE,
      ST_BLEND,
      ST_OUTPUT
   } back_state_type;

endpackage

FILE: rtl/rgfb_front.sv
// ----------------------------------------------------------------------------
// rgfb_front
// accepts transactions, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module rgfb_front
   import rgfb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_mode,
   input  logic [11:0]     req_cell_index,
   input  logic [1:0]      req_cell_state,
   input  logic [9:0]      req_pixel_x,
   input  logic [9:0]      req_pixel_y,
   input  logic [7:0]      req_base_red,
   input  logic [7:0]      req_base_green,
   input  logic [7:0]      req_base_blue,
   input  back_status_type back_status,
   input  logic            pop,
   output logic            head_valid,
   output item_type        head_item
);

   localparam logic [1:0] DEPTH = 2'd2;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item_in;
   logic       push;
   logic       take;

   always_comb begin
      item_in.op         = req_mode ? OP_COMPOSE : OP_WRITE;
      item_in.cell_index = req_cell_index;
      item_in.cell_state = req_cell_state;
      item_in.pixel_x    = req_pixel_x;
      item_in.pixel_y    = req_pixel_y;
      item_in.base_red   = req_base_red;
      item_in.base_green = req_base_green;
      item_in.base_blue  = req_base_blue;
   end

   assign req_stall  = (count_ff == DEPTH) || back_status.clearing;
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];
   assign take       = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/rgfb_back.sv
// ----------------------------------------------------------------------------
// rgfb_back
// visibility grid memory and the per-pixel rotate, sample and blend sequencer
// ----------------------------------------------------------------------------
module rgfb_back
   import rgfb_pkg::*;
#(
   parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            head_valid,
   input  item_type        head_item,
   output logic            pop,
   output back_status_type back_status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   output logic            rsp_fogged
);

   localparam int GRID_CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
   localparam int CW = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
   localparam int GW = $clog2(MAX_GRID_DIM + 1);
   localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int FW = $clog2(FRACTION_SCALE + 1);
   localparam int TW = 8 + FW;
   localparam int NW = TW + FW + 1;
   localparam int SW = 31 + FW;
   localparam int XW = CW + GW + 1;
   localparam int QSH = 2 * $clog2(FRACTION_SCALE);

   function automatic logic [7:0] alpha_of(input logic [1:0] s);
      logic [7:0] a;
      case (s)
         CELL_VISIBLE:  a = ALPHA_VISIBLE;
         CELL_EXPLORED: a = ALPHA_EXPLORED;
         default:       a = ALPHA_UNSEEN;
      endcase
      return a;
   endfunction

   function automatic logic [2*CW+FW-1:0] axis_split(input logic signed [53:0] g,
                                                    input logic [GW-1:0] dim);
      logic signed [23:0] b0;
      logic signed [23:0] b1;
      logic signed [23:0] top;
      logic [30:0]        rem;
      logic [SW-1:0]      scaled;
      logic [CW-1:0]      lo;
      logic [CW-1:0]      hi;
      logic [FW-1:0]      fr;
      b0     = 24'($signed(g[53:31]));
      b1     = b0 + 24'sd1;
      top    = $signed(24'(dim)) - 24'sd1;
      rem    = g[30:0];
      scaled = SW'(rem) * SW'(FRACTION_SCALE) + SW'(2 ** 30);
      fr     = FW'(scaled >> 31);
      if (b0 < 0) lo = '0;
      else if (b0 > top) lo = CW'(top);
      else lo = CW'(b0);
      if (b1 < 0) hi = '0;
      else if (b1 > top) hi = CW'(top);
      else hi = CW'(b1);
      return {lo, hi, fr};
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [GW-1:0] gw);
      logic [XW-1:0] t;
      t = XW'(row) * XW'(gw) + XW'(col);
      return AW'(t);
   endfunction

   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] s;
      s = 17'(v) + 17'(v >> 8) + 17'd1;
      return s[15:8];
   endfunction

   back_state_type state_ff, state_in;

   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [2:0]          rd_cnt_ff, rd_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [9:0]          px_ff, px_in, py_ff, py_in;
   logic [7:0]          red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic signed [27:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic signed [28:0]  wx_ff, wx_in, wy_ff, wy_in;
   logic signed [41:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic signed [53:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [CW-1:0]       x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [FW-1:0]       fx_ff, fx_in, fy_ff, fy_in;
   logic [AW-1:0]       addr_ff [4];
   logic [AW-1:0]       addr_in [4];
   logic [7:0]          alpha_ff [4];
   logic [7:0]          alpha_in [4];
   logic [TW-1:0]       top_ff, top_in, bot_ff, bot_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [7:0]          quo_ff, quo_in;
   logic [15:0]         vr_ff, vr_in, vg_ff, vg_in, vb_ff, vb_in;
   logic [7:0]          out_red_ff, out_red_in, out_green_ff, out_green_in;
   logic [7:0]          out_blue_ff, out_blue_in;
   logic                fogged_ff, fogged_in;

   logic [1:0]          mem [GRID_CELLS];
   logic [1:0]          mem_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [1:0]          mem_wdata;
   logic [AW-1:0]       mem_raddr;

   logic [GW-1:0]       gw_c, gh_c;
   logic signed [12:0]  cx_wide, cy_wide;
   logic signed [11:0]  cx, cy;
   logic [31:0]         idx_wide;
   logic [2*CW+FW-1:0]  split_x, split_y;
   logic [FW-1:0]       ix, iy;
   logic [7:0]          inv;

   always_comb begin
      if (cfg.grid_width == 7'd0) gw_c = GW'(1);
      else if (int'(cfg.grid_width) > MAX_GRID_DIM) gw_c = GW'(MAX_GRID_DIM);
      else gw_c = GW'(cfg.grid_width);
      if (cfg.grid_height == 7'd0) gh_c = GW'(1);
      else if (int'(cfg.grid_height) > MAX_GRID_DIM) gh_c = GW'(MAX_GRID_DIM);
      else gh_c = GW'(cfg.grid_height);
   end

   assign cx_wide  = $signed({2'b00, px_ff, 1'b0}) - $signed({2'b00, cfg.image_width});
   assign cy_wide  = $signed({2'b00, py_ff, 1'b0}) - $signed({2'b00, cfg.image_height});
   assign cx       = cx_wide[11:0];
   assign cy       = cy_wide[11:0];
   assign idx_wide = 32'(head_item.cell_index);
   assign split_x  = axis_split(gx_ff, gw_c);
   assign split_y  = axis_split(gy_ff, gh_c);
   assign ix       = FW'(FRACTION_SCALE) - fx_ff;
   assign iy       = FW'(FRACTION_SCALE) - fy_ff;
   assign inv      = CHANNEL_MAX - quo_ff;
   assign mem_raddr = addr_ff[rd_cnt_ff[1:0]];

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rd_cnt_in    = rd_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      px_in = px_ff;   py_in = py_ff;
      red_in = red_ff; green_in = green_ff; blue_in = blue_ff;
      pa_in = pa_ff;   pb_in = pb_ff;
      wx_in = wx_ff;   wy_in = wy_ff;
      sa_in = sa_ff;   sb_in = sb_ff;
      gx_in = gx_ff;   gy_in = gy_ff;
      x0_in = x0_ff;   x1_in = x1_ff;   y0_in = y0_ff;   y1_in = y1_ff;
      fx_in = fx_ff;   fy_in = fy_ff;
      addr_in  = addr_ff;
      alpha_in = alpha_ff;
      top_in = top_ff; bot_in = bot_ff;
      rem_in = rem_ff; quo_in = quo_ff;
      vr_in = vr_ff;   vg_in = vg_ff;   vb_in = vb_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      fogged_in    = fogged_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = 2'd0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(GRID_CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_item.op == OP_WRITE) begin
                  mem_we    = (idx_wide < 32'(GRID_CELLS));
                  mem_waddr = idx_wide[AW-1:0];
                  mem_wdata = head_item.cell_state;
               end else begin
                  px_in    = head_item.pixel_x;
                  py_in    = head_item.pixel_y;
                  red_in   = head_item.base_red;
                  green_in = head_item.base_green;
                  blue_in  = head_item.base_blue;
                  state_in = ST_ROT1;
               end
            end
         end
         ST_ROT1: begin
            pa_in    = 28'(cx) * 28'(cfg.yaw_cosine);
            pb_in    = 28'(cy) * 28'(cfg.yaw_sine);
            state_in = ST_ROT2;
         end
         ST_ROT2: begin
            wx_in    = 29'(pa_ff) + 29'(pb_ff);
            pa_in    = 28'(cy) * 28'(cfg.yaw_cosine);
            pb_in    = 28'(cx) * 28'(cfg.yaw_sine);
            state_in = ST_ROT3;
         end
         ST_ROT3: begin
            wy_in    = 29'(pa_ff) - 29'(pb_ff);
            state_in = ST_SCALE_X;
         end
         ST_SCALE_X: begin
            sa_in    = 42'(wx_ff) * 42'($signed({1'b0, cfg.scale_horizontal[11:0]}));
            sb_in    = 42'(wx_ff) * 42'($signed({1'b0, cfg.scale_horizontal[23:12]}));
            state_in = ST_SCALE_Y;
         end
         ST_SCALE_Y: begin
            gx_in    = (54'(sb_ff) <<< 12) + 54'(sa_ff) + (54'(gw_c) << 30);
            sa_in    = 42'(wy_ff) * 42'($signed({1'b0, cfg.scale_vertical[11:0]}));
            sb_in    = 42'(wy_ff) * 42'($signed({1'b0, cfg.scale_vertical[23:12]}));
            state_in = ST_GRID_Y;
         end
         ST_GRID_Y: begin
            gy_in    = (54'(sb_ff) <<< 12) + 54'(sa_ff) + (54'(gh_c) << 30);
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            {x0_in, x1_in, fx_in} = split_x;
            {y0_in, y1_in, fy_in} = split_y;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            addr_in[0] = cell_addr(y0_ff, x0_ff, gw_c);
            addr_in[1] = cell_addr(y0_ff, x1_ff, gw_c);
            addr_in[2] = cell_addr(y1_ff, x0_ff, gw_c);
            addr_in[3] = cell_addr(y1_ff, x1_ff, gw_c);
            rd_cnt_in  = 3'd0;
            state_in   = ST_READ;
         end
         ST_READ: begin
            if (rd_cnt_ff != 3'd0) begin
               alpha_in[2'(rd_cnt_ff - 3'd1)] = alpha_of(mem_q_ff);
            end
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) state_in = ST_LERP_ROW;
         end
         ST_LERP_ROW: begin
            top_in   = TW'(alpha_ff[0]) * TW'(ix) + TW'(alpha_ff[1]) * TW'(fx_ff);
            bot_in   = TW'(alpha_ff[2]) * TW'(ix) + TW'(alpha_ff[3]) * TW'(fx_ff);
            state_in = ST_LERP_COL;
         end
         ST_LERP_COL: begin
            rem_in   = NW'(top_ff) * NW'(iy) + NW'(bot_ff) * NW'(fy_ff);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            quo_in   = 8'(rem_ff >> QSH);
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            vr_in    = 16'(red_ff) * 16'(inv) + 16'(FOG_RED) * 16'(quo_ff);
            vg_in    = 16'(green_ff) * 16'(inv) + 16'(FOG_GREEN) * 16'(quo_ff);
            vb_in    = 16'(blue_ff) * 16'(inv) + 16'(FOG_BLUE) * 16'(quo_ff);
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_red_in   = div255(vr_ff);
               out_green_in = div255(vg_ff);
               out_blue_in  = div255(vb_ff);
               fogged_in    = (quo_ff != 8'd0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rd_cnt_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;   py_ff <= py_in;
      red_ff <= red_in; green_ff <= green_in; blue_ff <= blue_in;
      pa_ff <= pa_in;   pb_ff <= pb_in;
      wx_ff <= wx_in;   wy_ff <= wy_in;
      sa_ff <= sa_in;   sb_ff <= sb_in;
      gx_ff <= gx_in;   gy_ff <= gy_in;
      x0_ff <= x0_in;   x1_ff <= x1_in;   y0_ff <= y0_in;   y1_ff <= y1_in;
      fx_ff <= fx_in;   fy_ff <= fy_in;
      addr_ff  <= addr_in;
      alpha_ff <= alpha_in;
      top_ff <= top_in; bot_ff <= bot_in;
      rem_ff <= rem_in; quo_ff <= quo_in;
      vr_ff <= vr_in;   vg_ff <= vg_in;   vb_ff <= vb_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      fogged_ff    <= fogged_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_fogged    = fogged_ff;

endmodule

FILE: rtl/rotated_grid_fog_blend_unit.sv
// ----------------------------------------------------------------------------
// rotated_grid_fog_blend_unit
// pixels: handled one at a time by the back sequencer: six rotate and scale
//   steps, split and address steps, four reads on the single grid read port,
//   lerp, shift and blend steps, with no pop until the result is registered
// throughput of cell writes: one per cycle while the back sequencer is idle
// reset: a clearing pass marks all MAX_GRID_DIM squared cells unseen, with
//   req_stall held high; csr writes are taken throughout
// ----------------------------------------------------------------------------
module rotated_grid_fog_blend_unit
   import rgfb_pkg::*;
#(
   parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [11:0] req_cell_index,
   input  logic [1:0]  req_cell_state,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   input  logic [7:0]  req_base_red,
   input  logic [7:0]  req_base_green,
   input  logic [7:0]  req_base_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_fogged
);

   cfg_type         cfg_ff, cfg_in;
   back_status_type back_status;
   logic            head_valid;
   item_type        head_item;
   logic            pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:      cfg_in.image_width      = csr_write_data[10:0];
            CSR_IMAGE_HEIGHT:     cfg_in.image_height     = csr_write_data[10:0];
            CSR_GRID_WIDTH:       cfg_in.grid_width       = csr_write_data[6:0];
            CSR_GRID_HEIGHT:      cfg_in.grid_height      = csr_write_data[6:0];
            CSR_YAW_COSINE:       cfg_in.yaw_cosine       = csr_write_data[15:0];
            CSR_YAW_SINE:         cfg_in.yaw_sine         = csr_write_data[15:0];
            CSR_SCALE_HORIZONTAL: cfg_in.scale_horizontal = csr_write_data;
            CSR_SCALE_VERTICAL:   cfg_in.scale_vertical   = csr_write_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height     <= IMAGE_HEIGHT_RESET;
         cfg_ff.grid_width       <= GRID_WIDTH_RESET;
         cfg_ff.grid_height      <= GRID_HEIGHT_RESET;
         cfg_ff.yaw_cosine       <= YAW_COSINE_RESET;
         cfg_ff.yaw_sine         <= YAW_SINE_RESET;
         cfg_ff.scale_horizontal <= SCALE_H_RESET;
         cfg_ff.scale_vertical   <= SCALE_V_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_cell_index (req_cell_index),
      .req_cell_state (req_cell_state),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_base_red   (req_base_red),
      .req_base_green (req_base_green),
      .req_base_blue  (req_base_blue),
      .back_status    (back_status),
      .pop            (pop),
      .head_valid     (head_valid),
      .head_item      (head_item)
   );

   rgfb_back #(
      .MAX_GRID_DIM (MAX_GRID_DIM)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .back_status   (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_fogged    (rsp_fogged)
   );

   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !rsp_valid)
      else $error("result shown during grid clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> req_stall)
      else $error("request taken during grid clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop without queued transaction");

endmodule
